// File: src/ccc_pkg.sv
`default_nettype none
package ccc_pkg;

	localparam logic [1:0] CLASS_FLUID = 2'd0;
	localparam logic [1:0] CLASS_BODY  = 2'd1;
	localparam logic [1:0] CLASS_GHOST = 2'd2;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_OFFSET_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_OFFSET_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_RADIUS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GHOST_LAYERS_X  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GHOST_LAYERS_Y  = 3'd6;

	// Configuration as seen by the datapath; layer counts are already clamped.
	typedef struct packed {
		logic signed [31:0] off_x;
		logic signed [31:0] off_y;
		logic [30:0]        radius;
		logic [30:0]        wx;
		logic [30:0]        wy;
		logic [3:0]         gx;
		logic [3:0]         gy;
	} cfg_t;

	// Centre coordinates of the cell and of the outermost neighbour columns and rows.
	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] nxl;
		logic signed [31:0] nxh;
		logic signed [31:0] nyl;
		logic signed [31:0] nyh;
	} coord_set_t;

endpackage
`default_nettype wire

// File: src/ccc_ifs.sv
`default_nettype none
interface ccc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] cell_x;
	logic signed [15:0] cell_y;
	modport source (output valid, output cell_x, output cell_y, input ready);
	modport sink (input valid, input cell_x, input cell_y, output ready);
endinterface

interface ccc_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cell_class;
	logic [30:0]        wall_distance;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	modport source (output valid, output cell_class, output wall_distance,
		output normal_x, output normal_y, input ready);
	modport sink (input valid, input cell_class, input wall_distance,
		input normal_x, input normal_y, output ready);
endinterface

interface ccc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: src/ccc_front.sv
`default_nettype none
module ccc_front
	import ccc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	ccc_in_if.sink      cells,
	input  cfg_t        cfg,
	output coord_set_t  push_data,
	output logic        push_valid,
	input  wire logic   push_ready
);

	localparam logic [2:0] JOB_DONE = 3'd6;

	logic               busy_q;
	logic [2:0]         job_q;
	logic signed [15:0] ix_q;
	logic signed [15:0] iy_q;
	logic signed [49:0] prod_s1;
	logic [2:0]         tag_s1;
	logic               pv_s1;
	logic signed [31:0] coord_q [6];

	logic signed [17:0] idx;
	logic signed [17:0] ixe;
	logic signed [17:0] iye;
	logic [30:0]        wsel;
	logic signed [31:0] offsel;
	logic [29:0]        hwsel;
	logic signed [51:0] sum;
	logic signed [31:0] sat;
	logic               issue;

	assign ixe = {{2{ix_q[15]}}, ix_q};
	assign iye = {{2{iy_q[15]}}, iy_q};
	assign issue = busy_q && (job_q != JOB_DONE);

	// Jobs 0..2 are the x coordinates (cell, minus layers, plus layers), 3..5 the y ones.
	always_comb begin
		unique case (job_q)
			3'd0: idx = ixe;
			3'd1: idx = ixe - {14'd0, cfg.gx};
			3'd2: idx = ixe + {14'd0, cfg.gx};
			3'd3: idx = iye;
			3'd4: idx = iye - {14'd0, cfg.gy};
			3'd5: idx = iye + {14'd0, cfg.gy};
			default: idx = ixe;
		endcase
		wsel = (job_q < 3'd3) ? cfg.wx : cfg.wy;
	end

	always_comb begin
		offsel = (tag_s1 < 3'd3) ? cfg.off_x : cfg.off_y;
		hwsel = (tag_s1 < 3'd3) ? cfg.wx[30:1] : cfg.wy[30:1];
		sum = {{20{offsel[31]}}, offsel} + {{2{prod_s1[49]}}, prod_s1}
			+ $signed({22'd0, hwsel});
		if (sum > 52'sd2147483647) begin
			sat = 32'sh7fffffff;
		end else if (sum < -52'sd2147483648) begin
			sat = 32'sh80000000;
		end else begin
			sat = sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			job_q <= 3'd0;
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= issue;
			if (issue) begin
				job_q <= job_q + 3'd1;
			end
			if (!busy_q && cells.valid) begin
				busy_q <= 1'b1;
				job_q <= 3'd0;
			end else if (push_valid && push_ready) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && cells.valid) begin
			ix_q <= cells.cell_x;
			iy_q <= cells.cell_y;
		end
		if (issue) begin
			prod_s1 <= idx * $signed({1'b0, wsel});
			tag_s1 <= job_q;
		end
		if (pv_s1) begin
			coord_q[tag_s1] <= sat;
		end
	end

	assign cells.ready = !busy_q;
	assign push_valid = busy_q && (job_q == JOB_DONE) && !pv_s1;

	always_comb begin
		push_data.dx = coord_q[0];
		push_data.nxl = coord_q[1];
		push_data.nxh = coord_q[2];
		push_data.dy = coord_q[3];
		push_data.nyl = coord_q[4];
		push_data.nyh = coord_q[5];
	end

endmodule
`default_nettype wire

// File: src/ccc_fifo.sv
`default_nettype none
module ccc_fifo
	import ccc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  coord_set_t  push_data,
	input  wire logic   push_valid,
	output logic        push_ready,
	output coord_set_t  pop_data,
	output logic        pop_valid,
	input  wire logic   pop_ready
);

	coord_set_t mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// File: src/ccc_isqrt.sv
`default_nettype none
module ccc_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] value,
	output logic             done,
	output logic [31:0]      root
);

	logic        run_q;
	logic        done_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [63:0] trial;
	logic        ge;

	assign trial = r_q + bit_q;
	assign ge = (v_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (bit_q == 64'd1);
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && (bit_q == 64'd1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// One result bit per cycle; a 64-bit operand gives a 32-bit root.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			r_q <= 64'd0;
			bit_q <= 64'd1 << 62;
		end else if (run_q) begin
			if (ge) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule
`default_nettype wire

// File: src/ccc_back.sv
`default_nettype none
module ccc_back
	import ccc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  cfg_t        cfg,
	input  coord_set_t  item,
	input  wire logic   item_valid,
	output logic        item_ready,
	ccc_out_if.source   results
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_SQX  = 4'd3;
	localparam logic [3:0] S_SQY  = 4'd4;
	localparam logic [3:0] S_T1   = 4'd5;
	localparam logic [3:0] S_SQR  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	localparam logic [3:0] OP_SQ_DX  = 4'd0;
	localparam logic [3:0] OP_SQ_DY  = 4'd1;
	localparam logic [3:0] OP_SQ_R   = 4'd2;
	localparam logic [3:0] OP_SQ_NXL = 4'd3;
	localparam logic [3:0] OP_SQ_NXH = 4'd4;
	localparam logic [3:0] OP_SQ_NYL = 4'd5;
	localparam logic [3:0] OP_SQ_NYH = 4'd6;
	localparam logic [3:0] OP_LX     = 4'd7;
	localparam logic [3:0] OP_LY     = 4'd8;
	localparam logic [3:0] OP_END    = 4'd9;

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	logic [3:0]  state_q;
	coord_set_t  item_q;
	logic [3:0]  op_q;
	logic        mv_s1;
	logic [3:0]  mtag_s1;
	logic [63:0] prod_s1;
	logic [63:0] sqdx_q;
	logic [63:0] sqdy_q;
	logic [63:0] rr_q;
	logic [63:0] nbx_q;
	logic [63:0] nby_q;
	logic [34:0] lx_q;
	logic [34:0] ly_q;
	logic [31:0] sx_q;
	logic [31:0] r_q;
	logic        t2_q;
	logic [1:0]  cls_q;
	logic [46:0] remx_q;
	logic [46:0] remy_q;
	logic [46:0] den_q;
	logic [14:0] qx_q;
	logic [14:0] qy_q;
	logic [3:0]  cnt_q;

	logic        out_valid_q;
	logic [1:0]  out_class_q;
	logic [30:0] out_wall_q;
	logic [15:0] out_nx_q;
	logic [15:0] out_ny_q;

	logic [31:0] ma;
	logic [31:0] mb;
	logic [31:0] adx;
	logic [31:0] ady;
	logic [64:0] r2;
	logic [64:0] nbsum;
	logic        sq_start;
	logic [63:0] sq_val;
	logic        sq_done;
	logic [31:0] sq_root;
	logic [33:0] ex_d;
	logic [33:0] ey_d;
	logic [33:0] ex;
	logic [33:0] ey;
	logic        t1;
	logic        gex;
	logic        gey;
	logic [14:0] qxc;
	logic [14:0] qyc;
	logic        out_free;

	assign adx = abs32(item_q.dx);
	assign ady = abs32(item_q.dy);
	assign r2 = {1'b0, sqdx_q} + {1'b0, sqdy_q};
	assign nbsum = {1'b0, nbx_q} + {1'b0, nby_q};
	assign out_free = !out_valid_q || results.ready;
	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		unique case (op_q)
			OP_SQ_DX: begin
				ma = adx;
				mb = adx;
			end
			OP_SQ_DY: begin
				ma = ady;
				mb = ady;
			end
			OP_SQ_R: begin
				ma = {1'b0, cfg.radius};
				mb = {1'b0, cfg.radius};
			end
			OP_SQ_NXL: begin
				ma = abs32(item_q.nxl);
				mb = abs32(item_q.nxl);
			end
			OP_SQ_NXH: begin
				ma = abs32(item_q.nxh);
				mb = abs32(item_q.nxh);
			end
			OP_SQ_NYL: begin
				ma = abs32(item_q.nyl);
				mb = abs32(item_q.nyl);
			end
			OP_SQ_NYH: begin
				ma = abs32(item_q.nyh);
				mb = abs32(item_q.nyh);
			end
			OP_LX: begin
				ma = {28'd0, cfg.gx};
				mb = {1'b0, cfg.wx};
			end
			OP_LY: begin
				ma = {28'd0, cfg.gy};
				mb = {1'b0, cfg.wy};
			end
			default: begin
				ma = 32'd0;
				mb = 32'd0;
			end
		endcase
	end

	// First test: distance to the circle along each axis, within the layer band.
	always_comb begin
		ex_d = {2'b00, sx_q} - {2'b00, adx};
		ey_d = {2'b00, sq_root} - {2'b00, ady};
		ex = ex_d[33] ? (~ex_d + 34'd1) : ex_d;
		ey = ey_d[33] ? (~ey_d + 34'd1) : ey_d;
		t1 = ({2'b00, ex} < {1'b0, lx_q}) || ({2'b00, ey} < {1'b0, ly_q});
	end

	always_comb begin
		sq_start = 1'b0;
		sq_val = r2[63:0];
		case (state_q)
			S_CHK: begin
				sq_start = (r2 < {1'b0, rr_q});
				sq_val = rr_q - sqdy_q;
			end
			S_SQX: begin
				sq_start = sq_done;
				sq_val = rr_q - sqdx_q;
			end
			S_T1: begin
				sq_start = t1 || t2_q;
				sq_val = r2[63:0];
			end
			default: begin
				sq_start = 1'b0;
			end
		endcase
	end

	ccc_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (sq_val),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign gex = (remx_q >= den_q);
	assign gey = (remy_q >= den_q);
	assign qxc = (qx_q > 15'd16384) ? 15'd16384 : qx_q;
	assign qyc = (qy_q > 15'd16384) ? 15'd16384 : qy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mv_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mv_s1 <= (state_q == S_MUL) && (op_q != OP_END);
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (op_q == OP_END && !mv_s1) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= sq_start ? S_SQX : S_OUT;
				end
				S_SQX: begin
					if (sq_done) begin
						state_q <= S_SQY;
					end
				end
				S_SQY: begin
					if (sq_done) begin
						state_q <= S_T1;
					end
				end
				S_T1: begin
					state_q <= sq_start ? S_SQR : S_OUT;
				end
				S_SQR: begin
					if (sq_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == 4'd14) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			item_q <= item;
			op_q <= 4'd0;
		end
		if (state_q == S_MUL && op_q != OP_END) begin
			prod_s1 <= ma * mb;
			mtag_s1 <= op_q;
			op_q <= op_q + 4'd1;
		end
		if (mv_s1) begin
			case (mtag_s1)
				OP_SQ_DX: sqdx_q <= prod_s1;
				OP_SQ_DY: sqdy_q <= prod_s1;
				OP_SQ_R: rr_q <= prod_s1;
				OP_SQ_NXL: nbx_q <= prod_s1;
				OP_SQ_NXH: nbx_q <= (prod_s1 > nbx_q) ? prod_s1 : nbx_q;
				OP_SQ_NYL: nby_q <= prod_s1;
				OP_SQ_NYH: nby_q <= (prod_s1 > nby_q) ? prod_s1 : nby_q;
				OP_LX: lx_q <= prod_s1[34:0];
				OP_LY: ly_q <= prod_s1[34:0];
				default: ;
			endcase
		end
		if (state_q == S_CHK) begin
			cls_q <= CLASS_FLUID;
			// The farthest diagonal neighbour sits at a corner of the layer box.
			t2_q <= (cfg.gx != 4'd0) && (cfg.gy != 4'd0) && (nbsum > {1'b0, rr_q});
		end
		if (state_q == S_SQX && sq_done) begin
			sx_q <= sq_root;
		end
		if (state_q == S_T1) begin
			cls_q <= sq_start ? CLASS_GHOST : CLASS_BODY;
		end
		if (state_q == S_SQR && sq_done) begin
			r_q <= sq_root;
			remx_q <= {1'b0, adx, 14'd0} + {16'd0, sq_root[31:1]};
			remy_q <= {1'b0, ady, 14'd0} + {16'd0, sq_root[31:1]};
			den_q <= {1'b0, sq_root, 14'd0};
			qx_q <= 15'd0;
			qy_q <= 15'd0;
			cnt_q <= 4'd0;
		end
		if (state_q == S_DIV) begin
			if (gex) begin
				remx_q <= remx_q - den_q;
			end
			if (gey) begin
				remy_q <= remy_q - den_q;
			end
			qx_q <= {qx_q[13:0], gex};
			qy_q <= {qy_q[13:0], gey};
			den_q <= den_q >> 1;
			cnt_q <= cnt_q + 4'd1;
		end
		if (state_q == S_OUT && out_free) begin
			out_class_q <= cls_q;
			if (cls_q == CLASS_GHOST) begin
				out_wall_q <= cfg.radius - r_q[30:0];
				if (r_q == 32'd0) begin
					out_nx_q <= 16'd0;
					out_ny_q <= 16'd0;
				end else begin
					out_nx_q <= item_q.dx[31] ? (16'd0 - {1'b0, qxc}) : {1'b0, qxc};
					out_ny_q <= item_q.dy[31] ? (16'd0 - {1'b0, qyc}) : {1'b0, qyc};
				end
			end else begin
				out_wall_q <= 31'd0;
				out_nx_q <= 16'd0;
				out_ny_q <= 16'd0;
			end
		end
	end

	assign results.valid = out_valid_q;
	assign results.cell_class = out_class_q;
	assign results.wall_distance = out_wall_q;
	assign results.normal_x = out_nx_q;
	assign results.normal_y = out_ny_q;

endmodule
`default_nettype wire

// File: src/cylinder_cell_classifier.sv
// Front: a cell is taken when the front is free and its six centre coordinates are
// computed one after another on a single shared multiply-add, one job per coordinate.
// Back: a fluid cell needs only the shared multiplier, a body cell also two square roots
// and a ghost cell a third square root and the normal division; a two-entry queue lets
// the front run ahead of the back.
// Reset clears all control state and loads the register reset values; no clearing pass.
`default_nettype none
module cylinder_cell_classifier
	import ccc_pkg::*;
#(
	parameter int MAX_GHOST_LAYERS = 15
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ccc_in_if.sink    cells,
	ccc_out_if.source results,
	ccc_cfg_if.sink   cfg
);

	logic signed [31:0] off_x_q;
	logic signed [31:0] off_y_q;
	logic [30:0]        radius_q;
	logic [30:0]        wx_q;
	logic [30:0]        wy_q;
	logic [3:0]         gx_q;
	logic [3:0]         gy_q;
	cfg_t               cfg_v;
	coord_set_t         push_data;
	logic               push_valid;
	logic               push_ready;
	coord_set_t         pop_data;
	logic               pop_valid;
	logic               pop_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= -32'sd65536;
			off_y_q <= -32'sd65536;
			radius_q <= 31'd32768;
			wx_q <= 31'd655;
			wy_q <= 31'd655;
			gx_q <= 4'd2;
			gy_q <= 4'd2;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ORIGIN_OFFSET_X: off_x_q <= cfg.data;
				REG_ORIGIN_OFFSET_Y: off_y_q <= cfg.data;
				REG_CIRCLE_RADIUS: radius_q <= cfg.data[30:0];
				REG_CELL_WIDTH_X: wx_q <= cfg.data[30:0];
				REG_CELL_WIDTH_Y: wy_q <= cfg.data[30:0];
				REG_GHOST_LAYERS_X: gx_q <= cfg.data[3:0];
				REG_GHOST_LAYERS_Y: gy_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_v.off_x = off_x_q;
		cfg_v.off_y = off_y_q;
		cfg_v.radius = radius_q;
		cfg_v.wx = wx_q;
		cfg_v.wy = wy_q;
		cfg_v.gx = (gx_q > 4'(MAX_GHOST_LAYERS)) ? 4'(MAX_GHOST_LAYERS) : gx_q;
		cfg_v.gy = (gy_q > 4'(MAX_GHOST_LAYERS)) ? 4'(MAX_GHOST_LAYERS) : gy_q;
	end

	ccc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cells      (cells),
		.cfg        (cfg_v),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	ccc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	ccc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_v),
		.item       (pop_data),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.results    (results)
	);

endmodule
`default_nettype wire
